// File: sv/bcg_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the button click gesture detector
// no dependencies; used by every module of the block

package bcg_pkg;

  localparam int unsigned StampW    = 32;
  localparam int unsigned MsW       = 16;
  localparam int unsigned GestW     = 2;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 8;

  localparam logic [MsW-1:0] DebounceRst = 16'd50;
  localparam logic [MsW-1:0] HoldRst     = 16'd1000;
  localparam logic [MsW-1:0] WindowRst   = 16'd400;

  typedef enum logic [GestW-1:0] {
    GEST_NONE   = 2'd0,
    GEST_DOUBLE = 2'd1,
    GEST_LONG   = 2'd2
  } gesture_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PRESSED_LEVEL = 8'd0,
    REG_DEBOUNCE      = 8'd1,
    REG_HOLD          = 8'd2,
    REG_WINDOW        = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic           pressed_level;
    logic [MsW-1:0] debounce_ms;
    logic [MsW-1:0] hold_ms;
    logic [MsW-1:0] double_window_ms;
  } cfg_t;

  typedef struct packed {
    logic              level;
    logic [StampW-1:0] now_ms;
  } poll_t;

endpackage

// File: sv/bcg_cfg.sv
`timescale 1ns / 1ps
// configuration register file of the gesture detector
// depends on bcg_pkg

module bcg_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bcg_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bcg_pkg::CfgDataW-1:0]  cfg_data,
  output bcg_pkg::cfg_t                 cfg
);

  bcg_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pressed_level    <= 1'b1;
      cfg_r.debounce_ms      <= bcg_pkg::DebounceRst;
      cfg_r.hold_ms          <= bcg_pkg::HoldRst;
      cfg_r.double_window_ms <= bcg_pkg::WindowRst;
    end else if (cfg_valid) begin
      case (cfg_index)
        bcg_pkg::REG_PRESSED_LEVEL: cfg_r.pressed_level    <= cfg_data[0];
        bcg_pkg::REG_DEBOUNCE:      cfg_r.debounce_ms      <= cfg_data;
        bcg_pkg::REG_HOLD:          cfg_r.hold_ms          <= cfg_data;
        bcg_pkg::REG_WINDOW:        cfg_r.double_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: sv/bcg_in_reg.sv
`timescale 1ns / 1ps
// input register stage: holds one poll until the core takes it
// depends on bcg_pkg

module bcg_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bcg_pkg::poll_t in_poll,
  output logic           s1_valid,
  input  logic           s1_take,
  output bcg_pkg::poll_t s1_poll
);

  logic           valid_r;
  bcg_pkg::poll_t poll_r;

  assign in_ready = !valid_r || s1_take;
  assign s1_valid = valid_r;
  assign s1_poll  = poll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      poll_r <= in_poll;
    end
  end

endmodule

// File: sv/bcg_core.sv
`timescale 1ns / 1ps
// edge debounce, double click and long click state and decision logic
// depends on bcg_pkg

module bcg_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  bcg_pkg::poll_t    poll,
  input  bcg_pkg::cfg_t     cfg,
  output bcg_pkg::gesture_t gesture
);

  logic                        last_pressed_r, last_pressed_nxt;
  logic [bcg_pkg::StampW-1:0]  press_stamp_r, press_stamp_nxt;
  logic [bcg_pkg::StampW-1:0]  release_stamp_r, release_stamp_nxt;
  logic                        hold_reported_r, hold_reported_nxt;
  logic                        double_armed_r, double_armed_nxt;
  logic                        double_pending_r, double_pending_nxt;

  logic                        pressed;
  logic [bcg_pkg::StampW-1:0]  since_release;
  logic [bcg_pkg::StampW-1:0]  since_press;
  logic [bcg_pkg::StampW-1:0]  held_for;
  logic                        press_edge;
  logic                        release_edge;

  always_comb begin
    pressed       = (poll.level == cfg.pressed_level);
    since_release = poll.now_ms - release_stamp_r;
    since_press   = poll.now_ms - press_stamp_r;
    press_edge    = pressed && !last_pressed_r &&
                    (since_release > {16'd0, cfg.debounce_ms});
    release_edge  = !pressed && last_pressed_r &&
                    (since_press > {16'd0, cfg.debounce_ms});

    last_pressed_nxt   = pressed;
    press_stamp_nxt    = press_stamp_r;
    release_stamp_nxt  = release_stamp_r;
    hold_reported_nxt  = hold_reported_r;
    double_armed_nxt   = double_armed_r;
    double_pending_nxt = double_pending_r;
    gesture            = bcg_pkg::GEST_NONE;

    if (press_edge) begin
      press_stamp_nxt    = poll.now_ms;
      hold_reported_nxt  = 1'b0;
      // a third press inside the window disarms instead of arming
      double_armed_nxt   = (since_release < {16'd0, cfg.double_window_ms}) &&
                           !double_armed_r && double_pending_r;
      double_pending_nxt = 1'b0;
    end else if (release_edge) begin
      release_stamp_nxt = poll.now_ms;
      if (double_armed_r) begin
        double_pending_nxt = 1'b0;
        double_armed_nxt   = 1'b0;
        gesture            = bcg_pkg::GEST_DOUBLE;
      end else begin
        double_pending_nxt = 1'b1;
      end
    end

    // hold time is measured from the stamp as updated by this poll
    held_for = press_edge ? '0 : since_press;
    if (pressed && (held_for >= {16'd0, cfg.hold_ms}) && !hold_reported_nxt) begin
      gesture           = bcg_pkg::GEST_LONG;
      hold_reported_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pressed_r   <= 1'b0;
      press_stamp_r    <= '0;
      release_stamp_r  <= '0;
      hold_reported_r  <= 1'b0;
      double_armed_r   <= 1'b0;
      double_pending_r <= 1'b0;
    end else if (adv) begin
      last_pressed_r   <= last_pressed_nxt;
      press_stamp_r    <= press_stamp_nxt;
      release_stamp_r  <= release_stamp_nxt;
      hold_reported_r  <= hold_reported_nxt;
      double_armed_r   <= double_armed_nxt;
      double_pending_r <= double_pending_nxt;
    end
  end

  a_double_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && gesture == bcg_pkg::GEST_DOUBLE) |-> !pressed)
    else $error("double click reported while pressed");

  a_long_marks_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && gesture == bcg_pkg::GEST_LONG) |=> hold_reported_r)
    else $error("long click did not set hold_reported");

  a_double_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && gesture == bcg_pkg::GEST_DOUBLE) |=> (!double_armed_r && !double_pending_r))
    else $error("double click left detector armed");

  a_level_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && pressed) |=> last_pressed_r)
    else $error("last level not tracked");

endmodule

// File: sv/button_click_gesture_detector.sv
`timescale 1ns / 1ps
// Button click gesture detector. One poll (button level and millisecond
// timestamp) is taken per cycle while the output is not stalled and yields
// exactly one result (0 nothing, 1 double click, 2 long click): the poll is
// held in the input register, then the debounce and gesture logic updates its
// state and loads the output register. The sustained rate is one poll per
// cycle while out_tready holds the output from stalling. Configuration
// writes are always ready and must be made while no poll is in flight.
// depends on bcg_pkg, bcg_cfg, bcg_in_reg, bcg_core

module button_click_gesture_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bcg_pkg::InDataW-1:0]   in_tdata,   // [0] level, [32:1] now_ms, rest zero
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bcg_pkg::OutDataW-1:0]  out_tdata,  // [1:0] gesture, rest zero
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bcg_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bcg_pkg::CfgDataW-1:0]  cfg_data
);

  bcg_pkg::cfg_t     cfg;
  bcg_pkg::poll_t    in_poll;
  bcg_pkg::poll_t    s1_poll;
  bcg_pkg::gesture_t gesture;
  logic              s1_valid;
  logic              s1_take;
  logic              adv;
  logic              out_valid_r;
  bcg_pkg::gesture_t out_gesture_r;

  assign in_poll.level  = in_tdata[0];
  assign in_poll.now_ms = in_tdata[32:1];

  // the core steps whenever a poll is held and the output register can take a result
  assign s1_take = !out_valid_r || out_tready;
  assign adv     = s1_valid && s1_take;

  bcg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bcg_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_poll  (in_poll),
    .s1_valid (s1_valid),
    .s1_take  (s1_take),
    .s1_poll  (s1_poll)
  );

  bcg_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .poll    (s1_poll),
    .cfg     (cfg),
    .gesture (gesture)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_take) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_gesture_r <= gesture;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(bcg_pkg::OutDataW - bcg_pkg::GestW){1'b0}}, out_gesture_r};

endmodule

// File: tb/button_click_gesture_detector_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for button_click_gesture_detector: directed gesture cases, then
// random click traffic under several settings, each result checked against a local predictor
// depends on bcg_pkg and button_click_gesture_detector

module button_click_gesture_detector_tb;

  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned SettleCycles = 8;

  logic                         clk        = 1'b0;
  logic                         rst_n      = 1'b0;
  logic                         in_tvalid  = 1'b0;
  logic                         in_tready;
  logic [bcg_pkg::InDataW-1:0]  in_tdata   = '0;   // [0] level, [32:1] now_ms, rest zero
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [bcg_pkg::OutDataW-1:0] out_tdata;         // [1:0] gesture, rest zero
  logic                         cfg_valid  = 1'b0;
  logic                         cfg_ready;
  logic [bcg_pkg::CfgIdxW-1:0]  cfg_index  = '0;
  logic [bcg_pkg::CfgDataW-1:0] cfg_data   = '0;

  // settings as currently loaded into the block
  logic                    set_pressed_level = 1'b1;
  logic [bcg_pkg::MsW-1:0] set_debounce_ms   = bcg_pkg::DebounceRst;
  logic [bcg_pkg::MsW-1:0] set_hold_ms       = bcg_pkg::HoldRst;
  logic [bcg_pkg::MsW-1:0] set_window_ms     = bcg_pkg::WindowRst;

  // tracked detector state
  logic                       btn_was_pressed = 1'b0;
  logic [bcg_pkg::StampW-1:0] press_time      = '0;
  logic [bcg_pkg::StampW-1:0] release_time    = '0;
  logic                       long_given      = 1'b0;
  logic                       dbl_armed       = 1'b0;
  logic                       dbl_pending     = 1'b0;

  bcg_pkg::gesture_t          gestures_due[$];
  int unsigned                failures    = 0;
  int unsigned                polls_sent  = 0;
  int unsigned                burst_left  = 0;
  int unsigned                cycle_count = 0;
  int unsigned                stall_tick  = 0;
  logic [bcg_pkg::StampW-1:0] poll_clock  = '0;

  button_click_gesture_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("button_click_gesture_detector verification failed");
      $finish;
    end
  end

  // receiver backpressure, mode chosen by stall_tick bits [9:8]
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    case (stall_tick[9:8])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 3) != 0);
      2'd2: out_tready <= stall_tick[4];
      default: out_tready <= (stall_tick[1:0] == 2'd0);
    endcase
  end

  function automatic bcg_pkg::gesture_t gesture_for_poll(input logic lvl,
                                                         input logic [bcg_pkg::StampW-1:0] now);
    logic                       pressed;
    logic [bcg_pkg::StampW-1:0] since_rel;
    logic [bcg_pkg::StampW-1:0] since_prs;
    bcg_pkg::gesture_t          g;
    pressed   = (lvl == set_pressed_level);
    since_rel = now - release_time;
    since_prs = now - press_time;
    g         = bcg_pkg::GEST_NONE;
    if (pressed && !btn_was_pressed && since_rel > bcg_pkg::StampW'(set_debounce_ms)) begin
      press_time  = now;
      long_given  = 1'b0;
      // a press while already armed disarms
      dbl_armed   = (since_rel < bcg_pkg::StampW'(set_window_ms)) && !dbl_armed && dbl_pending;
      dbl_pending = 1'b0;
    end else if (!pressed && btn_was_pressed &&
                 since_prs > bcg_pkg::StampW'(set_debounce_ms)) begin
      release_time = now;
      if (dbl_armed) begin
        dbl_armed   = 1'b0;
        dbl_pending = 1'b0;
        g           = bcg_pkg::GEST_DOUBLE;
      end else begin
        dbl_pending = 1'b1;
      end
    end
    // hold test needs no accepted press, only the level and the stamp
    since_prs = now - press_time;
    if (pressed && since_prs >= bcg_pkg::StampW'(set_hold_ms) && !long_given) begin
      g          = bcg_pkg::GEST_LONG;
      long_given = 1'b1;
    end
    btn_was_pressed = pressed;
    return g;
  endfunction

  always @(posedge clk) begin
    logic [bcg_pkg::GestW-1:0] seen;
    bcg_pkg::gesture_t         want;
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata[bcg_pkg::GestW-1:0];
      if (gestures_due.size() == 0) begin
        $error("gesture result %0d with no request outstanding", seen);
        failures++;
      end else begin
        want = gestures_due.pop_front();
        if (seen !== want) begin
          $error("gesture: expected %0d, got %0d", want, seen);
          failures++;
        end
      end
    end
  end

  task automatic send_poll(input logic lvl, input logic [bcg_pkg::StampW-1:0] stamp);
    int unsigned gap;
    in_tdata  <= {7'd0, stamp, lvl};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    gestures_due.push_back(gesture_for_poll(lvl, stamp));
    polls_sent++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      case ($urandom_range(0, 9))
        0, 1: gap = 0;
        2: gap = $urandom_range(8, 40);
        default: gap = $urandom_range(1, 4);
      endcase
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop requests and wait until every outstanding gesture has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    while (gestures_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input bcg_pkg::cfg_reg_t idx,
                           input logic [bcg_pkg::CfgDataW-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input logic lvl, input logic [bcg_pkg::MsW-1:0] deb,
                               input logic [bcg_pkg::MsW-1:0] hold,
                               input logic [bcg_pkg::MsW-1:0] win);
    settle();
    write_reg(bcg_pkg::REG_PRESSED_LEVEL, bcg_pkg::CfgDataW'(lvl));
    write_reg(bcg_pkg::REG_DEBOUNCE, deb);
    write_reg(bcg_pkg::REG_HOLD, hold);
    write_reg(bcg_pkg::REG_WINDOW, win);
    cfg_valid         <= 1'b0;
    set_pressed_level = lvl;
    set_debounce_ms   = deb;
    set_hold_ms       = hold;
    set_window_ms     = win;
  endtask

  // one level held over a span, split into a few polls
  task automatic drive_level(input bit pressed, input int unsigned span);
    int unsigned npolls;
    npolls = $urandom_range(1, 3);
    repeat (npolls) begin
      send_poll(pressed ? set_pressed_level : ~set_pressed_level, poll_clock);
      poll_clock += span / npolls;
    end
  endtask

  task automatic random_gestures(input int unsigned count);
    int unsigned target;
    int unsigned deb;
    int unsigned short_ms;
    int unsigned idle_ms;
    target = polls_sent + count;
    deb    = 32'(set_debounce_ms);
    while (polls_sent < target) begin
      short_ms = deb + 1 + $urandom_range(0, 200);
      idle_ms  = deb + 1 + $urandom_range(0, 2 * set_window_ms + 100);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          drive_level(1'b1, short_ms);
          drive_level(1'b0, deb + 1 + $urandom_range(0, set_window_ms + 50));
          drive_level(1'b1, deb + 1 + $urandom_range(0, 200));
          drive_level(1'b0, idle_ms);
        end
        4, 5: begin
          drive_level(1'b1, set_hold_ms + 3 + $urandom_range(0, 300));
          send_poll(set_pressed_level, poll_clock);
          drive_level(1'b0, idle_ms);
        end
        6: begin
          drive_level(1'b1, short_ms);
          drive_level(1'b0, idle_ms);
        end
        7, 8: begin
          // contact bounce around an edge
          repeat ($urandom_range(2, 6)) begin
            send_poll(1'($urandom_range(0, 1)), poll_clock);
            poll_clock += $urandom_range(0, deb);
          end
        end
        default: begin
          poll_clock = $urandom();
          send_poll(1'($urandom_range(0, 1)), poll_clock);
        end
      endcase
    end
  endtask

  task automatic test_power_up_hold();
    send_poll(1'b1, 32'd0);
    send_poll(1'b1, 32'd1000);
    send_poll(1'b0, 32'd1100);
  endtask

  task automatic test_double_click();
    send_poll(1'b1, 32'd1200);
    send_poll(1'b0, 32'd1300);
    send_poll(1'b1, 32'd1400);
    send_poll(1'b0, 32'd1500);
    send_poll(1'b1, 32'd1600);
    send_poll(1'b0, 32'd1620);
    send_poll(1'b1, 32'd1630);
    send_poll(1'b0, 32'd1800);
    send_poll(1'b1, 32'd2200);
    send_poll(1'b0, 32'd2300);
    send_poll(1'b1, 32'd2350);
  endtask

  task automatic test_timestamp_wrap();
    load_settings(1'b1, bcg_pkg::DebounceRst, bcg_pkg::HoldRst, bcg_pkg::WindowRst);
    send_poll(1'b0, 32'hFFFF_FD00);
    send_poll(1'b1, 32'hFFFF_FE00);
    send_poll(1'b0, 32'hFFFF_FF00);
    send_poll(1'b1, 32'h0000_0010);
    send_poll(1'b0, 32'h0000_0080);
    send_poll(1'b1, 32'h7FFF_FFFF);
    send_poll(1'b1, 32'h8000_03E7);
  endtask

  task automatic test_active_low_zero_times();
    load_settings(1'b0, 16'd0, 16'd0, 16'hFFFF);
    send_poll(1'b0, 32'd100);
    send_poll(1'b1, 32'd101);
    send_poll(1'b0, 32'd101);
    send_poll(1'b1, 32'd102);
    send_poll(1'b0, 32'd30000);
    send_poll(1'b1, 32'd30001);
  endtask

  task automatic test_extreme_times();
    load_settings(1'b1, 16'hFFFF, 16'hFFFF, 16'd0);
    send_poll(1'b1, 32'd200000);
    send_poll(1'b1, 32'd265535);
    send_poll(1'b0, 32'd265536);
    poll_clock = 32'd400000;
  endtask

  task automatic test_random_traffic();
    load_settings(1'b1, bcg_pkg::DebounceRst, bcg_pkg::HoldRst, bcg_pkg::WindowRst);
    random_gestures(250);
    load_settings(1'b0, bcg_pkg::MsW'($urandom_range(0, 80)),
                  bcg_pkg::MsW'($urandom_range(100, 1500)),
                  bcg_pkg::MsW'($urandom_range(50, 800)));
    random_gestures(250);
    load_settings(1'($urandom_range(0, 1)), 16'd0, bcg_pkg::MsW'($urandom_range(0, 200)),
                  bcg_pkg::MsW'($urandom_range(0, 300)));
    random_gestures(200);
    load_settings(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_gestures(100);
    load_settings(1'b1, bcg_pkg::MsW'($urandom_range(1, 30)),
                  bcg_pkg::MsW'($urandom_range(1, 60)),
                  bcg_pkg::MsW'($urandom_range(200, 2000)));
    random_gestures(150);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_power_up_hold();
    test_double_click();
    test_timestamp_wrap();
    test_active_low_zero_times();
    test_extreme_times();
    test_random_traffic();
    settle();
    if (failures == 0) begin
      $display("button_click_gesture_detector verification clean");
    end else begin
      $display("button_click_gesture_detector verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/bcg_pkg.sv
sv/bcg_cfg.sv
sv/bcg_in_reg.sv
sv/bcg_core.sv
sv/button_click_gesture_detector.sv
tb/button_click_gesture_detector_tb.sv
